// ----- rtl/core/x86_instruction_field_decoder_top_assert.svh -----
// Assertion macros used by the decoder top module.
`ifndef X86_INSTRUCTION_FIELD_DECODER_TOP_ASSERT_SVH
`define X86_INSTRUCTION_FIELD_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define X86FD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define X86FD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/x86fd_pkg.sv -----
package x86fd_pkg;

    typedef enum logic [2:0] {
        PH_OPCODE = 3'd0,
        PH_MODRM  = 3'd1,
        PH_SIB    = 3'd2,
        PH_DISP8  = 3'd3,
        PH_DISP32 = 3'd4,
        PH_IMM8   = 3'd5,
        PH_IMM32  = 3'd6,
        PH_DONE   = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        TL_NONE  = 3'd0,
        TL_IMM8  = 3'd1,
        TL_IMM32 = 3'd2,
        TL_REL8  = 3'd3,
        TL_REL32 = 3'd4
    } t_tail;

    localparam logic [7:0] OP_ADD_RM   = 8'h01;
    localparam logic [7:0] OP_ADD_R    = 8'h03;
    localparam logic [7:0] OP_SUB_RM   = 8'h29;
    localparam logic [7:0] OP_SUB_R    = 8'h2b;
    localparam logic [7:0] OP_GRP1_I32 = 8'h81;
    localparam logic [7:0] OP_GRP1_I8  = 8'h83;
    localparam logic [7:0] OP_MOV_I8   = 8'hc6;
    localparam logic [7:0] OP_MOV_I32  = 8'hc7;
    localparam logic [7:0] OP_RET      = 8'hc3;
    localparam logic [7:0] OP_LEAVE    = 8'hc9;
    localparam logic [7:0] OP_CALL     = 8'he8;
    localparam logic [7:0] OP_JMP32    = 8'he9;
    localparam logic [7:0] OP_JMP8     = 8'heb;

    localparam logic [1:0] MOD_NODISP = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP32 = 2'd2;
    localparam logic [1:0] MOD_REG    = 2'd3;
    localparam logic [2:0] RM_SIB     = 3'd4;
    localparam logic [2:0] RM_ABS     = 3'd5;
    localparam logic [3:0] LEN_MAX    = 4'd15;

    typedef struct packed {
        logic [31:0] fetch_address;
        logic [31:0] start_address;
        t_phase      phase;
        logic [1:0]  byte_cnt;
        logic [7:0]  opcode;
        logic [7:0]  modrm;
        logic [7:0]  sib;
        logic [31:0] disp;
        logic [31:0] imm;
        logic [3:0]  len;
    } t_state;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [7:0]  modrm;
        logic [7:0]  sib;
        logic [7:0]  disp8;
        logic [31:0] disp32;
        logic [7:0]  imm8;
        logic [31:0] imm32;
        logic [7:0]  rel8;
        logic [31:0] rel32;
        logic [3:0]  length;
        logic        known;
        logic [31:0] instr_address;
    } t_result;

    function automatic logic has_modrm(input logic [7:0] op);
        return op == OP_ADD_RM || op == OP_ADD_R || op == OP_SUB_RM || op == OP_SUB_R ||
               op == OP_GRP1_I32 || op == OP_GRP1_I8 || op[7:2] == 6'b100010 ||
               op == OP_MOV_I8 || op == OP_MOV_I32;
    endfunction

    function automatic logic is_known(input logic [7:0] op);
        return has_modrm(op) || op[7:4] == 4'h5 || op[7:4] == 4'hb ||
               op == OP_RET || op == OP_LEAVE || op == OP_CALL ||
               op == OP_JMP32 || op == OP_JMP8;
    endfunction

    function automatic t_tail tail_kind(input logic [7:0] op);
        if (op == OP_GRP1_I32 || op == OP_MOV_I32 || op == OP_CALL || op[7:3] == 5'b10111)
            return TL_IMM32;
        if (op == OP_GRP1_I8 || op == OP_MOV_I8 || op[7:3] == 5'b10110)
            return TL_IMM8;
        if (op == OP_JMP32)
            return TL_REL32;
        if (op == OP_JMP8)
            return TL_REL8;
        return TL_NONE;
    endfunction

    function automatic t_phase tail_phase(input logic [7:0] op);
        t_tail k;
        k = tail_kind(op);
        if (k == TL_IMM8 || k == TL_REL8)
            return PH_IMM8;
        if (k == TL_IMM32 || k == TL_REL32)
            return PH_IMM32;
        return PH_DONE;
    endfunction

    function automatic logic uses_disp32(input logic [7:0] modrm);
        return modrm[7:6] == MOD_DISP32 || (modrm[7:6] == MOD_NODISP && modrm[2:0] == RM_ABS);
    endfunction

    function automatic t_phase disp_phase(input logic [7:0] modrm, input logic [7:0] op);
        if (uses_disp32(modrm))
            return PH_DISP32;
        if (modrm[7:6] == MOD_DISP8)
            return PH_DISP8;
        return tail_phase(op);
    endfunction

endpackage

// ----- rtl/core/x86_instruction_field_decoder_top.sv -----
// Byte-serial field decoder for a subset of 32-bit x86 code. One beat per clock
// is taken while o_in_ready is high: a code byte (i_cmd = 0) or a fetch-address
// load (i_cmd = 1) that drops any partial instruction. Each beat passes an input
// register, the phase/field update logic and a result register, so a completed
// instruction reaches the output once its last byte moves on from the input
// register. Sustained rate is one beat per cycle, throttled only by i_out_ready
// on the result register. Address loads and non-final bytes produce no result;
// an unknown opcode gives a one-byte result with o_known low.
module x86_instruction_field_decoder_top
    import x86fd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_code_byte,
    input  logic [31:0] i_new_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_opcode,
    output logic [7:0]  o_modrm,
    output logic [7:0]  o_sib,
    output logic [7:0]  o_disp8,
    output logic [31:0] o_disp32,
    output logic [7:0]  o_imm8,
    output logic [31:0] o_imm32,
    output logic [7:0]  o_rel8,
    output logic [31:0] o_rel32,
    output logic [3:0]  o_length,
    output logic        o_known,
    output logic [31:0] o_instr_address
);

`include "x86_instruction_field_decoder_top_assert.svh"

    logic        r_in_valid;
    logic        r_cmd;
    logic [7:0]  r_code_byte;
    logic [31:0] r_new_address;
    logic        r_out_valid;
    t_result     r_res;
    logic        advance;
    logic        emit;
    t_result     res;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd         <= i_cmd;
            r_code_byte   <= i_code_byte;
            r_new_address <= i_new_address;
        end
    end

    x86fd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_cmd         (r_cmd),
        .i_code_byte   (r_code_byte),
        .i_new_address (r_new_address),
        .o_emit        (emit),
        .o_result      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_res <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_opcode        = r_res.opcode;
    assign o_modrm         = r_res.modrm;
    assign o_sib           = r_res.sib;
    assign o_disp8         = r_res.disp8;
    assign o_disp32        = r_res.disp32;
    assign o_imm8          = r_res.imm8;
    assign o_imm32         = r_res.imm32;
    assign o_rel8          = r_res.rel8;
    assign o_rel32         = r_res.rel32;
    assign o_length        = r_res.length;
    assign o_known         = r_res.known;
    assign o_instr_address = r_res.instr_address;

    // an address load never creates a result beat
    `X86FD_ASSERT_NXT(a_load_no_result, advance && r_cmd, o_out_valid == ($past(o_out_valid) && !$past(i_out_ready)), "address load produced a result")
    `X86FD_ASSERT_IMP(a_length_range, o_out_valid, o_length != 4'd0 && o_length <= 4'd11, "instruction length out of range")
    `X86FD_ASSERT_IMP(a_unknown_form, o_out_valid && !o_known, o_length == 4'd1 && o_opcode == 8'd0, "bad unknown-opcode result")

endmodule

// ----- rtl/core/x86fd_step.sv -----
module x86fd_step
    import x86fd_pkg::*;
(
    input  t_state      i_state,
    input  logic        i_cmd,
    input  logic [7:0]  i_code_byte,
    input  logic [31:0] i_new_address,
    output t_state      o_state,
    output logic        o_emit,
    output t_result     o_result
);

    t_state  s;
    t_phase  nxt;
    logic    known;
    logic [1:0] cnt_inc;
    logic [31:0] placed;
    t_tail   k;

    // byte lands in lane byte_cnt of a 32-bit field
    always_comb begin
        case (i_state.byte_cnt)
            2'd0:    placed = {24'd0, i_code_byte};
            2'd1:    placed = {16'd0, i_code_byte, 8'd0};
            2'd2:    placed = {8'd0, i_code_byte, 16'd0};
            default: placed = {i_code_byte, 24'd0};
        endcase
    end

    always_comb begin
        s       = i_state;
        nxt     = PH_OPCODE;
        known   = 1'b1;
        o_emit  = 1'b0;
        cnt_inc = i_state.byte_cnt + 2'd1;
        if (i_cmd) begin
            s.fetch_address = i_new_address;
            s.phase    = PH_OPCODE;
            s.byte_cnt = '0;
            s.opcode   = '0;
            s.modrm    = '0;
            s.sib      = '0;
            s.disp     = '0;
            s.imm      = '0;
            s.len      = '0;
        end else begin
            if (i_state.phase == PH_OPCODE || i_state.phase == PH_DONE) begin
                s.byte_cnt = '0;
                s.opcode   = '0;
                s.modrm    = '0;
                s.sib      = '0;
                s.disp     = '0;
                s.imm      = '0;
                s.len      = '0;
                s.start_address = i_state.fetch_address;
            end
            s.fetch_address = i_state.fetch_address + 32'd1;
            if (s.len < LEN_MAX)
                s.len = s.len + 4'd1;
            case (i_state.phase)
                PH_MODRM: begin
                    s.modrm = i_code_byte;
                    if (i_code_byte[7:6] != MOD_REG && i_code_byte[2:0] == RM_SIB)
                        nxt = PH_SIB;
                    else
                        nxt = disp_phase(i_code_byte, i_state.opcode);
                end
                PH_SIB: begin
                    s.sib = i_code_byte;
                    nxt   = disp_phase(i_state.modrm, i_state.opcode);
                end
                PH_DISP8: begin
                    s.disp = {24'd0, i_code_byte};
                    nxt    = tail_phase(i_state.opcode);
                end
                PH_DISP32: begin
                    s.disp     = i_state.disp | placed;
                    s.byte_cnt = cnt_inc;
                    nxt        = (cnt_inc == 2'd0) ? tail_phase(i_state.opcode) : PH_DISP32;
                end
                PH_IMM8: begin
                    s.imm = {24'd0, i_code_byte};
                    nxt   = PH_DONE;
                end
                PH_IMM32: begin
                    s.imm      = i_state.imm | placed;
                    s.byte_cnt = cnt_inc;
                    nxt        = (cnt_inc == 2'd0) ? PH_DONE : PH_IMM32;
                end
                default: begin
                    if (!is_known(i_code_byte)) begin
                        known = 1'b0;
                        nxt   = PH_DONE;
                    end else begin
                        s.opcode = i_code_byte;
                        nxt = has_modrm(i_code_byte) ? PH_MODRM : tail_phase(i_code_byte);
                    end
                end
            endcase
            if (nxt == PH_DONE) begin
                o_emit  = 1'b1;
                s.phase = PH_OPCODE;
            end else begin
                s.phase = nxt;
            end
        end
    end

    // result fields; holds are already clear for an unknown opcode
    always_comb begin
        o_result = '0;
        k = tail_kind(s.opcode);
        if (known) begin
            o_result.opcode = s.opcode;
            if (has_modrm(s.opcode)) begin
                o_result.modrm = s.modrm;
                o_result.sib   = s.sib;
                if (s.modrm[7:6] == MOD_DISP8)
                    o_result.disp8 = s.disp[7:0];
                else if (uses_disp32(s.modrm))
                    o_result.disp32 = s.disp;
            end
            case (k)
                TL_IMM8:  o_result.imm8  = s.imm[7:0];
                TL_IMM32: o_result.imm32 = s.imm;
                TL_REL8:  o_result.rel8  = s.imm[7:0];
                TL_REL32: o_result.rel32 = s.imm;
                default:  ;
            endcase
        end
        o_result.length        = s.len;
        o_result.known         = known;
        o_result.instr_address = s.start_address;
    end

    assign o_state = s;

endmodule

// ----- rtl/core/x86fd_core.sv -----
module x86fd_core
    import x86fd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_cmd,
    input  logic [7:0]  i_code_byte,
    input  logic [31:0] i_new_address,
    output logic        o_emit,
    output t_result     o_result
);

    t_state r_state;
    t_state n_state;

    x86fd_step u_step (
        .i_state       (r_state),
        .i_cmd         (i_cmd),
        .i_code_byte   (i_code_byte),
        .i_new_address (i_new_address),
        .o_state       (n_state),
        .o_emit        (o_emit),
        .o_result      (o_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

endmodule

// ----- dv/x86_instruction_field_decoder_checker.sv -----
module x86_instruction_field_decoder_checker
    import x86fd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_code_byte,
    input  logic [31:0] i_new_address,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_result     i_result,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] OP_PUSH_FIRST  = 8'h50;
    localparam logic [7:0] OP_POP_LAST    = 8'h5f;
    localparam logic [7:0] OP_MOVRM_FIRST = 8'h88;
    localparam logic [7:0] OP_MOVRM_LAST  = 8'h8b;
    localparam logic [7:0] OP_MOVB_FIRST  = 8'hb0;
    localparam logic [7:0] OP_MOVB_LAST   = 8'hb7;
    localparam logic [7:0] OP_MOVD_FIRST  = 8'hb8;
    localparam logic [7:0] OP_MOVD_LAST   = 8'hbf;
    localparam int         MAX_REPORTS    = 10;

    // decoder shadow state
    t_phase      phase;
    logic [31:0] pc;
    logic [31:0] first_pc;
    logic [1:0]  nbytes;
    logic [7:0]  op_r;
    logic [7:0]  modrm_r;
    logic [7:0]  sib_r;
    logic [31:0] disp_r;
    logic [31:0] imm_r;
    logic [3:0]  len_r;

    t_result instr_q[$];
    int      fail_count;

    function automatic logic takes_modrm(input logic [7:0] op);
        return op == OP_ADD_RM || op == OP_ADD_R || op == OP_SUB_RM || op == OP_SUB_R ||
               op == OP_GRP1_I32 || op == OP_GRP1_I8 || op == OP_MOV_I8 ||
               op == OP_MOV_I32 || (op >= OP_MOVRM_FIRST && op <= OP_MOVRM_LAST);
    endfunction

    function automatic t_tail trailer_of(input logic [7:0] op);
        if (op == OP_GRP1_I32 || op == OP_MOV_I32 || op == OP_CALL ||
            (op >= OP_MOVD_FIRST && op <= OP_MOVD_LAST))
            return TL_IMM32;
        if (op == OP_GRP1_I8 || op == OP_MOV_I8 || (op >= OP_MOVB_FIRST && op <= OP_MOVB_LAST))
            return TL_IMM8;
        if (op == OP_JMP32)
            return TL_REL32;
        if (op == OP_JMP8)
            return TL_REL8;
        return TL_NONE;
    endfunction

    function automatic logic opcode_listed(input logic [7:0] op);
        return takes_modrm(op) || trailer_of(op) != TL_NONE || op == OP_RET ||
               op == OP_LEAVE || (op >= OP_PUSH_FIRST && op <= OP_POP_LAST);
    endfunction

    function automatic t_phase trailer_phase(input logic [7:0] op);
        case (trailer_of(op))
            TL_IMM8, TL_REL8:   return PH_IMM8;
            TL_IMM32, TL_REL32: return PH_IMM32;
            default:            return PH_DONE;
        endcase
    endfunction

    function automatic logic wide_disp(input logic [7:0] mrm);
        return mrm[7:6] == MOD_DISP32 || (mrm[7:6] == MOD_NODISP && mrm[2:0] == RM_ABS);
    endfunction

    function automatic t_phase after_modrm(input logic [7:0] mrm, input logic [7:0] op);
        if (wide_disp(mrm))
            return PH_DISP32;
        if (mrm[7:6] == MOD_DISP8)
            return PH_DISP8;
        return trailer_phase(op);
    endfunction

    function automatic t_result build_result(input logic known);
        t_result r;
        r = '0;
        if (known) begin
            r.opcode = op_r;
            if (takes_modrm(op_r)) begin
                r.modrm = modrm_r;
                r.sib   = sib_r;
                if (modrm_r[7:6] == MOD_DISP8)
                    r.disp8 = disp_r[7:0];
                else if (wide_disp(modrm_r))
                    r.disp32 = disp_r;
            end
            case (trailer_of(op_r))
                TL_IMM8:  r.imm8  = imm_r[7:0];
                TL_IMM32: r.imm32 = imm_r;
                TL_REL8:  r.rel8  = imm_r[7:0];
                TL_REL32: r.rel32 = imm_r;
                default:  ;
            endcase
        end
        r.length        = len_r;
        r.known         = known;
        r.instr_address = first_pc;
        return r;
    endfunction

    task automatic clear_fields();
        op_r    = '0;
        modrm_r = '0;
        sib_r   = '0;
        disp_r  = '0;
        imm_r   = '0;
        nbytes  = '0;
        len_r   = '0;
    endtask

    task automatic step_decoder(input logic cmd, input logic [7:0] b, input logic [31:0] addr);
        t_phase nxt;
        nxt = PH_DONE;
        if (cmd) begin
            // address load drops any partial instruction
            pc    = addr;
            phase = PH_OPCODE;
            clear_fields();
        end else begin
            if (phase == PH_OPCODE || phase == PH_DONE) begin
                clear_fields();
                first_pc = pc;
            end
            pc = pc + 32'd1;
            if (len_r != LEN_MAX)
                len_r = len_r + 4'd1;
            case (phase)
                PH_MODRM: begin
                    modrm_r = b;
                    if (b[7:6] != MOD_REG && b[2:0] == RM_SIB)
                        nxt = PH_SIB;
                    else
                        nxt = after_modrm(b, op_r);
                end
                PH_SIB: begin
                    sib_r = b;
                    nxt   = after_modrm(modrm_r, op_r);
                end
                PH_DISP8: begin
                    disp_r = {24'd0, b};
                    nxt    = trailer_phase(op_r);
                end
                PH_DISP32: begin
                    disp_r = disp_r | ({24'd0, b} << (8 * nbytes));
                    nbytes = nbytes + 2'd1;
                    nxt    = (nbytes == 2'd0) ? trailer_phase(op_r) : PH_DISP32;
                end
                PH_IMM8: begin
                    imm_r = {24'd0, b};
                    nxt   = PH_DONE;
                end
                PH_IMM32: begin
                    imm_r  = imm_r | ({24'd0, b} << (8 * nbytes));
                    nbytes = nbytes + 2'd1;
                    nxt    = (nbytes == 2'd0) ? PH_DONE : PH_IMM32;
                end
                default: begin
                    if (opcode_listed(b)) begin
                        op_r = b;
                        nxt  = takes_modrm(b) ? PH_MODRM : trailer_phase(b);
                    end else begin
                        // unknown opcode closes a one-byte instruction
                        instr_q.push_back(build_result(1'b0));
                        nxt = PH_OPCODE;
                    end
                end
            endcase
            if (nxt == PH_DONE) begin
                instr_q.push_back(build_result(1'b1));
                phase = PH_OPCODE;
            end else begin
                phase = nxt;
            end
        end
    endtask

    function automatic string show(input t_result r);
        return $sformatf({"op=%h modrm=%h sib=%h disp8=%h disp32=%h imm8=%h imm32=%h ",
                          "rel8=%h rel32=%h len=%0d known=%b addr=%h"},
                         r.opcode, r.modrm, r.sib, r.disp8, r.disp32, r.imm8, r.imm32,
                         r.rel8, r.rel32, r.length, r.known, r.instr_address);
    endfunction

    task automatic flag(input string what, input string exp_s, input string got_s);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] %s\n    expected: %s\n    actual:   %s", $realtime, what, exp_s,
                     got_s);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            pc       = '0;
            first_pc = '0;
            phase    = PH_OPCODE;
            clear_fields();
            instr_q.delete();
            fail_count = 0;
        end else begin
            if (i_in_valid && i_in_ready)
                step_decoder(i_cmd, i_code_byte, i_new_address);
            if (i_out_valid && i_out_ready) begin
                if (instr_q.size() == 0) begin
                    flag("result beat with nothing expected", "none", show(i_result));
                end else begin
                    want = instr_q.pop_front();
                    if (i_result !== want)
                        flag("result field mismatch", show(want), show(i_result));
                end
            end
        end
        o_errors  <= fail_count;
        o_pending <= instr_q.size();
    end

endmodule

// ----- dv/x86_instruction_field_decoder_top_tb.sv -----
module x86_instruction_field_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import x86fd_pkg::*;

    localparam logic [7:0] OP_PUSH_FIRST  = 8'h50;
    localparam logic [7:0] OP_MOVRM_FIRST = 8'h88;
    localparam logic [7:0] OP_MOVRM_LAST  = 8'h8b;
    localparam logic [7:0] OP_MOVB_FIRST  = 8'hb0;
    localparam logic [7:0] OP_MOVD_FIRST  = 8'hb8;
    localparam logic [7:0] UNDEF_OP_LOW   = 8'h00;
    localparam logic [7:0] UNDEF_OP_HIGH  = 8'hff;
    localparam int         PHASE_BEATS    = 138;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         DRAIN_CYCLES   = 10;

    // instruction shapes used to build well-formed byte streams
    typedef enum int {
        FM_MODRM, FM_MODRM_I32, FM_MODRM_I8, FM_BARE, FM_I8, FM_I32, FM_REL32, FM_REL8
    } t_form;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic        cmd         = 1'b0;
    logic [7:0]  code_byte   = '0;
    logic [31:0] new_address = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [7:0]  res_opcode, res_modrm, res_sib, res_disp8, res_imm8, res_rel8;
    logic [31:0] res_disp32, res_imm32, res_rel32, res_instr_address;
    logic [3:0]  res_length;
    logic        res_known;
    t_result     dut_result;

    int         fail_total;
    int         expect_left;
    int         beats_sent      = 0;
    int         sender_idle_pct = 0;
    int         recv_stall_pct  = 0;
    int         quiet_cycles    = 0;
    logic [7:0] byte_seq[$];

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    x86_instruction_field_decoder_top u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_cmd          (cmd),
        .i_code_byte    (code_byte),
        .i_new_address  (new_address),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_opcode       (res_opcode),
        .o_modrm        (res_modrm),
        .o_sib          (res_sib),
        .o_disp8        (res_disp8),
        .o_disp32       (res_disp32),
        .o_imm8         (res_imm8),
        .o_imm32        (res_imm32),
        .o_rel8         (res_rel8),
        .o_rel32        (res_rel32),
        .o_length       (res_length),
        .o_known        (res_known),
        .o_instr_address(res_instr_address)
    );

    assign dut_result = {res_opcode, res_modrm, res_sib, res_disp8, res_disp32, res_imm8,
                         res_imm32, res_rel8, res_rel32, res_length, res_known,
                         res_instr_address};

    x86_instruction_field_decoder_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_cmd        (cmd),
        .i_code_byte  (code_byte),
        .i_new_address(new_address),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_result     (dut_result),
        .o_errors     (fail_total),
        .o_pending    (expect_left)
    );

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // hang detection: no beat on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic [7:0] fields_byte(input logic [1:0] hi, input logic [2:0] mid,
                                               input logic [2:0] lo);
        return {hi, mid, lo};
    endfunction

    function automatic logic [7:0] pick_opcode(input t_form form);
        int pick;
        case (form)
            FM_MODRM: begin
                pick = $urandom_range(7);
                case (pick)
                    0:       return OP_ADD_RM;
                    1:       return OP_ADD_R;
                    2:       return OP_SUB_RM;
                    3:       return OP_SUB_R;
                    default: return OP_MOVRM_FIRST + 8'(pick - 4);
                endcase
            end
            FM_MODRM_I32: return $urandom_range(1) ? OP_GRP1_I32 : OP_MOV_I32;
            FM_MODRM_I8:  return $urandom_range(1) ? OP_GRP1_I8 : OP_MOV_I8;
            FM_BARE: begin
                pick = $urandom_range(17);
                if (pick == 16)
                    return OP_RET;
                if (pick == 17)
                    return OP_LEAVE;
                return OP_PUSH_FIRST + 8'(pick);
            end
            FM_I8: return OP_MOVB_FIRST + 8'($urandom_range(7));
            FM_I32: begin
                pick = $urandom_range(8);
                return (pick == 8) ? OP_CALL : OP_MOVD_FIRST + 8'(pick);
            end
            FM_REL32: return OP_JMP32;
            default:  return OP_JMP8;
        endcase
    endfunction

    task automatic put_beat(input logic c, input logic [7:0] b, input logic [31:0] a);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        code_byte   <= b;
        new_address <= a;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    task automatic load_address(input logic [31:0] a);
        put_beat(1'b1, 8'($urandom), a);
    endtask

    task automatic send_bytes(input int count);
        for (int k = 0; k < count; k++)
            put_beat(1'b0, byte_seq[k], $urandom);
        byte_seq.delete();
    endtask

    task automatic build_instr();
        t_form      form;
        logic [7:0] mrm;
        form = t_form'($urandom_range(7));
        byte_seq.delete();
        byte_seq.push_back(pick_opcode(form));
        if (form == FM_MODRM || form == FM_MODRM_I32 || form == FM_MODRM_I8) begin
            mrm = 8'($urandom);
            byte_seq.push_back(mrm);
            if (mrm[7:6] != MOD_REG && mrm[2:0] == RM_SIB)
                byte_seq.push_back(8'($urandom));
            if (mrm[7:6] == MOD_DISP32 || (mrm[7:6] == MOD_NODISP && mrm[2:0] == RM_ABS))
                repeat (4) byte_seq.push_back(8'($urandom));
            else if (mrm[7:6] == MOD_DISP8)
                byte_seq.push_back(8'($urandom));
        end
        if (form == FM_MODRM_I32 || form == FM_I32 || form == FM_REL32)
            repeat (4) byte_seq.push_back(8'($urandom));
        else if (form == FM_MODRM_I8 || form == FM_I8 || form == FM_REL8)
            byte_seq.push_back(8'($urandom));
    endtask

    task automatic random_mix(input int beats);
        int          stop_at;
        int          roll;
        logic [31:0] addr;
        stop_at = beats_sent + beats;
        while (beats_sent < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                build_instr();
                send_bytes(byte_seq.size());
            end else if (roll < 80) begin
                put_beat(1'b0, 8'($urandom), $urandom);
            end else if (roll < 88) begin
                addr = $urandom;
                if ($urandom_range(3) == 0)
                    addr = 32'hffff_fff0 | 32'($urandom_range(15));
                load_address(addr);
            end else begin
                // truncated instruction, cut off by an address load
                build_instr();
                if (byte_seq.size() > 1)
                    send_bytes($urandom_range(byte_seq.size() - 1, 1));
                else
                    send_bytes(1);
                load_address($urandom);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // start close to the top so the long instruction wraps the address
        load_address(32'hffff_fffc);
        put_beat(1'b0, UNDEF_OP_LOW, 32'h0000_0000);
        put_beat(1'b0, UNDEF_OP_HIGH, 32'hffff_ffff);
        // longest form: mod 2 with SIB, disp32 and imm32
        byte_seq = {OP_GRP1_I32, fields_byte(MOD_DISP32, 3'd0, RM_SIB),
                    fields_byte(2'd3, 3'd5, RM_ABS), 8'hff, 8'hff, 8'hff, 8'hff,
                    8'h00, 8'h80, 8'h7f, 8'h01};
        send_bytes(byte_seq.size());
        // SIB base 5 with mod 0: no displacement follows
        byte_seq = {OP_MOVRM_FIRST + 8'd1, fields_byte(MOD_NODISP, 3'd2, RM_SIB),
                    fields_byte(2'd0, 3'd1, RM_ABS)};
        send_bytes(byte_seq.size());
        // absolute disp32 form
        byte_seq = {OP_MOVRM_LAST, fields_byte(MOD_NODISP, 3'd7, RM_ABS),
                    8'h78, 8'h56, 8'h34, 8'h12};
        send_bytes(byte_seq.size());
        // address load in the middle of a call drops it
        byte_seq = {OP_CALL, 8'h12, 8'h34};
        send_bytes(byte_seq.size());
        load_address(32'h0000_0000);

        random_mix(PHASE_BEATS);
        sender_idle_pct = 72;
        random_mix(PHASE_BEATS);
        sender_idle_pct = 0;
        recv_stall_pct  = 72;
        random_mix(PHASE_BEATS);
        sender_idle_pct = 11;
        recv_stall_pct  = 11;
        random_mix(PHASE_BEATS);

        in_valid <= 1'b0;
        @(posedge clk);
        while (expect_left != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_total == 0 && expect_left == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
